@@ hdl/kmsd_pkg.sv @@
// Shared types, constants and helpers for the key matrix scan debounce unit.
// No dependencies.
package kmsd_pkg;

  localparam int ColIdxW   = 4;
  localparam int RowBitsW  = 5;
  localparam int CountW    = 7;
  localparam int ScansW    = 8;
  localparam logic [ScansW-1:0] DebounceReset = 8'd5;

  // status from the image store toward the countdown
  typedef struct packed {
    logic changed;
  } img_stat_t;

  // status from the countdown toward the image store and result
  typedef struct packed {
    logic              commit;
    logic              settled;
    logic [ScansW-1:0] countdown;
  } cd_stat_t;

  // number of set bits in one column
  function automatic logic [2:0] col_pop(input logic [RowBitsW-1:0] v);
    logic [2:0] n;
    n = '0;
    for (int i = 0; i < RowBitsW; i++) begin
      n = n + 3'(v[i]);
    end
    return n;
  endfunction

endpackage

@@ hdl/key_matrix_scan_debounce_unit.sv @@
// Top level of the key matrix scan debounce unit: request and result registers.
// Depends on kmsd_pkg, kmsd_image, kmsd_countdown.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one column sample per request:
//   column_index, row_bits and scan_end. Each request gives exactly one result
//   on the output channel (out_valid/out_ready).
//   Config channel (cfg_valid/cfg_ready, cfg_data) sets the debounce length in
//   full scans; cfg_ready is always high. Write it only while no request is
//   in flight.
//   Path: a request lands in an input register; the image/countdown update
//   runs from there into the result register, which drives the outputs.
//   Throughput: 1 request per cycle while the receiver does not stall.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more request, so in_ready falls only once both
//   are full.
//   Reset (rst, synchronous): images cleared, debounce length and countdown
//   set to 5, both registers empty.
module key_matrix_scan_debounce_unit #(
  parameter int ROWS = 5,
  parameter int COLS = 14
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [kmsd_pkg::ColIdxW-1:0]     column_index,
  input  logic [kmsd_pkg::RowBitsW-1:0]    row_bits,
  input  logic                             scan_end,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [kmsd_pkg::RowBitsW-1:0]    stable_column,
  output logic                             bit_changed,
  output logic                             settled,
  output logic                             committed,
  output logic [kmsd_pkg::CountW-1:0]      pressed_count,
  output logic [kmsd_pkg::ScansW-1:0]      countdown_now,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [kmsd_pkg::ScansW-1:0]      cfg_data
);

  logic                           req_valid;
  logic [kmsd_pkg::ColIdxW-1:0]   req_col;
  logic [kmsd_pkg::RowBitsW-1:0]  req_rows;
  logic                           req_end;
  logic                           step;
  kmsd_pkg::img_stat_t            img_stat;
  kmsd_pkg::cd_stat_t             cd_stat;
  logic [kmsd_pkg::RowBitsW-1:0]  stable_col;
  logic [kmsd_pkg::CountW-1:0]    pressed;

  assign step      = req_valid && (!out_valid || out_ready);
  assign in_ready  = !req_valid || step;
  assign cfg_ready = 1'b1;

  kmsd_image #(.ROWS(ROWS), .COLS(COLS)) u_image (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .column_index (req_col),
    .row_bits     (req_rows),
    .cd_stat      (cd_stat),
    .img_stat     (img_stat),
    .stable_col   (stable_col),
    .pressed      (pressed)
  );

  kmsd_countdown u_countdown (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid),
    .cfg_data (cfg_data),
    .step     (step),
    .scan_end (req_end),
    .img_stat (img_stat),
    .cd_stat  (cd_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        req_valid <= 1'b1;
      end else if (step) begin
        req_valid <= 1'b0;
      end
      if (step) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      req_col  <= column_index;
      req_rows <= row_bits;
      req_end  <= scan_end;
    end
    if (step) begin
      stable_column <= stable_col;
      bit_changed   <= img_stat.changed;
      settled       <= cd_stat.settled;
      committed     <= cd_stat.commit;
      pressed_count <= pressed;
      countdown_now <= cd_stat.countdown;
    end
  end

endmodule

@@ hdl/kmsd_countdown.sv @@
// Debounce length register and shared countdown.
// Depends on kmsd_pkg.
module kmsd_countdown (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [kmsd_pkg::ScansW-1:0]    cfg_data,
  input  logic                           step,
  input  logic                           scan_end,
  input  kmsd_pkg::img_stat_t            img_stat,
  output kmsd_pkg::cd_stat_t             cd_stat
);

  logic [kmsd_pkg::ScansW-1:0] debounce_scans;
  logic [kmsd_pkg::ScansW-1:0] countdown;
  logic [kmsd_pkg::ScansW-1:0] countdown_mid;
  logic [kmsd_pkg::ScansW-1:0] countdown_next;
  logic                        dec;

  always_comb begin
    countdown_mid  = img_stat.changed ? debounce_scans : countdown;
    // a reload on the last column is decremented in the same request
    dec            = scan_end && (countdown_mid != '0);
    countdown_next = dec ? countdown_mid - 1'b1 : countdown_mid;
    cd_stat.commit    = dec && (countdown_next == '0);
    cd_stat.settled   = (countdown_next == '0);
    cd_stat.countdown = countdown_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_scans <= kmsd_pkg::DebounceReset;
      countdown      <= kmsd_pkg::DebounceReset;
    end else begin
      if (cfg_we) begin
        debounce_scans <= cfg_data;
      end
      if (step) begin
        countdown <= countdown_next;
      end
    end
  end

endmodule

@@ hdl/kmsd_image.sv @@
// Raw and stable key images with running pressed-key counts.
// Depends on kmsd_pkg.
module kmsd_image #(
  parameter int ROWS = 5,
  parameter int COLS = 14
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            step,
  input  logic [kmsd_pkg::ColIdxW-1:0]    column_index,
  input  logic [kmsd_pkg::RowBitsW-1:0]   row_bits,
  input  kmsd_pkg::cd_stat_t              cd_stat,
  output kmsd_pkg::img_stat_t             img_stat,
  output logic [kmsd_pkg::RowBitsW-1:0]   stable_col,
  output logic [kmsd_pkg::CountW-1:0]     pressed
);

  // row bits above the input width can never be set
  localparam int SW = (ROWS < kmsd_pkg::RowBitsW) ? ROWS : kmsd_pkg::RowBitsW;
  localparam int CW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam logic [kmsd_pkg::RowBitsW-1:0] RowMask =
    kmsd_pkg::RowBitsW'((64'd1 << SW) - 64'd1);

  logic [SW-1:0] raw_image    [COLS];
  logic [SW-1:0] stable_image [COLS];
  logic [kmsd_pkg::CountW-1:0] raw_count;
  logic [kmsd_pkg::CountW-1:0] raw_count_next;
  logic [kmsd_pkg::CountW-1:0] stable_count;

  logic                          in_range;
  logic [CW-1:0]                 idx;
  logic [SW-1:0]                 rows;
  logic [kmsd_pkg::RowBitsW-1:0] raw_old;
  logic [kmsd_pkg::RowBitsW-1:0] rows_ext;
  logic [kmsd_pkg::RowBitsW-1:0] stable_old;
  logic                          write_raw;

  always_comb begin
    in_range   = ({1'b0, column_index} < (kmsd_pkg::ColIdxW+1)'(COLS));
    idx        = CW'(column_index);
    rows       = SW'(row_bits & RowMask);
    rows_ext   = kmsd_pkg::RowBitsW'(rows);
    raw_old    = kmsd_pkg::RowBitsW'(raw_image[idx]);
    stable_old = kmsd_pkg::RowBitsW'(stable_image[idx]);
    write_raw  = in_range && (raw_old != rows_ext);
    img_stat.changed = write_raw;
    raw_count_next = write_raw
      ? raw_count + kmsd_pkg::CountW'(kmsd_pkg::col_pop(rows_ext))
                  - kmsd_pkg::CountW'(kmsd_pkg::col_pop(raw_old))
      : raw_count;
    // after a commit the column reads the freshly written raw value
    if (!in_range) begin
      stable_col = '0;
    end else if (cd_stat.commit) begin
      stable_col = write_raw ? rows_ext : raw_old;
    end else begin
      stable_col = stable_old;
    end
    pressed = cd_stat.commit ? raw_count_next : stable_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_count    <= '0;
      stable_count <= '0;
      for (int c = 0; c < COLS; c++) begin
        raw_image[c]    <= '0;
        stable_image[c] <= '0;
      end
    end else if (step) begin
      raw_count <= raw_count_next;
      if (write_raw) begin
        raw_image[idx] <= rows;
      end
      if (cd_stat.commit) begin
        stable_count <= raw_count_next;
        for (int c = 0; c < COLS; c++) begin
          stable_image[c] <= (write_raw && (CW'(c) == idx)) ? rows : raw_image[c];
        end
      end
    end
  end

endmodule

@@ hdl/kmsd_checker.sv @@
// Port-level checks for the key matrix scan debounce unit, bound to the top.
// Depends on kmsd_pkg and key_matrix_scan_debounce_unit.
module kmsd_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_ready,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  logic [kmsd_pkg::RowBitsW-1:0]    stable_column,
  input  logic                             settled,
  input  logic                             committed,
  input  logic [kmsd_pkg::ScansW-1:0]      countdown_now
);

  // settled flag tracks a zero countdown
  a_settled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (settled == (countdown_now == '0)))
    else $error("settled disagrees with countdown");

  a_commit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && committed) |-> (settled && countdown_now == '0))
    else $error("commit with nonzero countdown");

  // both stages are empty on the first edge out of reset
  a_reset_ready: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> (in_ready && !out_valid))
    else $error("not ready after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(stable_column)))
    else $error("stalled result changed");

endmodule

bind key_matrix_scan_debounce_unit kmsd_checker u_kmsd_checker (.*);

@@ verif/tb_key_matrix_scan_debounce_unit.sv @@
// Testbench for key_matrix_scan_debounce_unit: queue-fed column-sample driver, result monitor
// and a cycle-free predictor of the raw/stable images and the shared debounce countdown.
// Depends on kmsd_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_key_matrix_scan_debounce_unit;

  localparam int NumRows = 5;
  localparam int NumCols = 14;

  typedef struct packed {
    logic [kmsd_pkg::ColIdxW-1:0]   col_idx;
    logic [kmsd_pkg::RowBitsW-1:0]  rows;
    logic                           last;
  } scan_item_t;

  typedef struct packed {
    logic [kmsd_pkg::RowBitsW-1:0]  stable_col;
    logic                           changed;
    logic                           quiet;
    logic                           commit;
    logic [kmsd_pkg::CountW-1:0]    keys_down;
    logic [kmsd_pkg::ScansW-1:0]    countdown;
  } column_report_t;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  logic [kmsd_pkg::ColIdxW-1:0]   column_index = '0;
  logic [kmsd_pkg::RowBitsW-1:0]  row_bits = '0;
  logic                           scan_end = 1'b0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  logic [kmsd_pkg::RowBitsW-1:0]  stable_column;
  logic                           bit_changed;
  logic                           settled;
  logic                           committed;
  logic [kmsd_pkg::CountW-1:0]    pressed_count;
  logic [kmsd_pkg::ScansW-1:0]    countdown_now;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [kmsd_pkg::ScansW-1:0]    cfg_data = '0;

  key_matrix_scan_debounce_unit #(
    .ROWS(NumRows),
    .COLS(NumCols)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .column_index(column_index),
    .row_bits(row_bits),
    .scan_end(scan_end),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .stable_column(stable_column),
    .bit_changed(bit_changed),
    .settled(settled),
    .committed(committed),
    .pressed_count(pressed_count),
    .countdown_now(countdown_now),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  logic [kmsd_pkg::RowBitsW-1:0] raw_img    [NumCols];
  logic [kmsd_pkg::RowBitsW-1:0] stable_img [NumCols];
  logic [kmsd_pkg::ScansW-1:0]   scan_cd;
  logic [kmsd_pkg::ScansW-1:0]   debounce_len;

  scan_item_t      sample_queue[$];
  column_report_t  column_reports[$];
  scan_item_t      cur_sample;
  logic            hold_sender = 1'b0;
  int              burst_left = 0;
  int              gap_left = 0;
  int              errors = 0;
  logic [kmsd_pkg::RowBitsW-1:0] held_keys [NumCols];

  function automatic column_report_t debounce_step(scan_item_t it);
    column_report_t r;
    int cnt;
    r = '0;
    cnt = 0;
    if (it.col_idx < NumCols) begin
      if (raw_img[it.col_idx] != it.rows) begin
        raw_img[it.col_idx] = it.rows;
        scan_cd = debounce_len;
        r.changed = 1'b1;
      end
    end
    // decrement follows the reload, so a change on the last column counts once
    if (it.last && scan_cd != 0) begin
      scan_cd = scan_cd - 1'b1;
      if (scan_cd == 0) begin
        stable_img = raw_img;
        r.commit = 1'b1;
      end
    end
    if (it.col_idx < NumCols) r.stable_col = stable_img[it.col_idx];
    for (int i = 0; i < NumCols; i++) begin
      for (int b = 0; b < kmsd_pkg::RowBitsW; b++) cnt += int'(stable_img[i][b]);
    end
    r.keys_down = kmsd_pkg::CountW'(cnt);
    r.quiet = (scan_cd == 0);
    r.countdown = scan_cd;
    return r;
  endfunction

  task automatic reset_predictor();
    for (int i = 0; i < NumCols; i++) begin
      raw_img[i] = '0;
      stable_img[i] = '0;
      held_keys[i] = '0;
    end
    debounce_len = kmsd_pkg::DebounceReset;
    scan_cd = kmsd_pkg::DebounceReset;
  endtask

  // driver: bursts of requests with random gaps
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) column_reports.push_back(debounce_step(cur_sample));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (hold_sender || sample_queue.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          cur_sample = sample_queue.pop_front();
          column_index <= cur_sample.col_idx;
          row_bits <= cur_sample.rows;
          scan_end <= cur_sample.last;
          in_valid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 12);
          end
          burst_left--;
          if (burst_left == 0) gap_left = $urandom_range(1, 6);
        end
      end
    end
  end

  task automatic check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, fname, want, got);
      errors++;
    end
  endtask

  // monitor: receiver stalls follow a randomly chosen ready mode that is redrawn when its run ends
  int ready_mode = 0;
  int mode_left = 0;
  int mode_tick = 0;

  always @(posedge clk) begin
    column_report_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (column_reports.size() == 0) begin
          $display("%0t: result with nothing expected, actual stable_column %0d", $time,
                   stable_column);
          errors++;
        end else begin
          want = column_reports.pop_front();
          check_field("stable_column", want.stable_col, stable_column);
          check_field("bit_changed", want.changed, bit_changed);
          check_field("settled", want.quiet, settled);
          check_field("committed", want.commit, committed);
          check_field("pressed_count", want.keys_down, pressed_count);
          check_field("countdown_now", want.countdown, countdown_now);
        end
      end
      if (mode_left == 0) begin
        ready_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 60);
      end
      mode_left--;
      mode_tick++;
      case (ready_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 1) == 1);
        default: out_ready <= ((mode_tick % 8) < 2);
      endcase
    end
  end

  task automatic push_sample(int col, int rows, bit last);
    scan_item_t it;
    it.col_idx = kmsd_pkg::ColIdxW'(col);
    it.rows = kmsd_pkg::RowBitsW'(rows);
    it.last = last;
    sample_queue.push_back(it);
  endtask

  // one full scan of held keys; a key pattern changes now and then, sometimes bouncing
  task automatic queue_scan();
    int c;
    if ($urandom_range(0, 2) == 0) begin
      c = $urandom_range(0, NumCols - 1);
      held_keys[c] = ($urandom_range(0, 1) == 0) ? held_keys[c] ^ (5'd1 << $urandom_range(0, 4))
                                                 : kmsd_pkg::RowBitsW'($urandom());
    end
    for (int i = 0; i < NumCols; i++) begin
      if ($urandom_range(0, 40) == 0) push_sample(i, held_keys[i] ^ 5'h01, i == NumCols - 1);
      else push_sample(i, held_keys[i], i == NumCols - 1);
    end
  endtask

  task automatic queue_phase(int n);
    int stop;
    while (sample_queue.size() < n) begin
      case ($urandom_range(0, 9))
        8: begin
          repeat ($urandom_range(1, 6))
            push_sample($urandom_range(0, 15), $urandom_range(0, 31),
                        $urandom_range(0, 1) == 1);
        end
        9: begin
          // scan cut short at a random column, which may or may not end the scan
          stop = $urandom_range(0, NumCols - 1);
          for (int i = 0; i <= stop; i++)
            push_sample(i, held_keys[i], (i == stop) && $urandom_range(0, 1));
        end
        default: queue_scan();
      endcase
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (sample_queue.size() != 0 || in_valid || column_reports.size() != 0);
  endtask

  task automatic write_debounce_len(logic [kmsd_pkg::ScansW-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    debounce_len = v;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    @(negedge clk);
  endtask

  initial begin
    int lens [7];
    int n;
    reset_predictor();
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset state, then an out-of-range column that still ends a scan
    push_sample(0, 0, 1'b0);
    push_sample(15, 31, 1'b1);
    wait_drained();
    write_debounce_len(8'd1);

    // all keys down: change on the last column reloads and commits in the same request
    for (int i = 0; i < NumCols; i++) push_sample(i, 31, i == NumCols - 1);
    push_sample(14, 5'h15, 1'b0);
    push_sample(3, 5'h0A, 1'b1);
    push_sample(3, 5'h0A, 1'b1);
    push_sample(7, 0, 1'b0);
    push_sample(13, 0, 1'b1);
    wait_drained();
    for (int i = 0; i < NumCols; i++) held_keys[i] = raw_img[i];

    lens = '{2, 255, 0, 3, 1, 0, 5};
    lens[5] = $urandom_range(4, 12);
    foreach (lens[p]) begin
      write_debounce_len(kmsd_pkg::ScansW'(lens[p]));
      n = 130 + $urandom_range(0, 10);
      queue_phase(n);
      if (p == 0) begin
        // let the unit drain completely mid-stream
        do @(negedge clk);
        while (sample_queue.size() > n / 2);
        hold_sender = 1'b1;
        do @(negedge clk);
        while (in_valid || column_reports.size() != 0);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && column_reports.size() == 0) begin
      $display("tb_key_matrix_scan_debounce_unit: clean");
    end else begin
      $display("tb_key_matrix_scan_debounce_unit: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("%0t: timeout", $time);
    $display("tb_key_matrix_scan_debounce_unit: errors");
    $finish;
  end

endmodule

@@ sim.f @@
hdl/kmsd_pkg.sv
hdl/kmsd_countdown.sv
hdl/kmsd_image.sv
hdl/key_matrix_scan_debounce_unit.sv
hdl/kmsd_checker.sv
verif/tb_key_matrix_scan_debounce_unit.sv
